### src/sha_pkg.sv
// shared types, constants and functions for the sha-256 pair hash block
// no dependencies
package sha_pkg;

    localparam int unsigned ROUNDS = 64;

    typedef logic [31:0] word_t;
    typedef word_t [7:0] state_t;
    typedef word_t [15:0] sched_t;

    localparam state_t INIT_H = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam word_t PAD_FIRST = 32'h80000000;
    localparam word_t PAD_LAST  = 32'h00000200;

    function automatic word_t round_k(input logic [5:0] t);
        word_t k;
        case (t)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic word_t rotr(input word_t x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

### src/sha_round.sv
// one sha-256 compression round with message schedule update, one register stage
// depends on sha_pkg
module sha_round #(
    parameter logic [5:0] RND = 6'd0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  sha_pkg::state_t in_v,
    input  sha_pkg::sched_t in_w,
    input  sha_pkg::state_t in_h,
    output logic            out_valid,
    output sha_pkg::state_t out_v,
    output sha_pkg::sched_t out_w,
    output sha_pkg::state_t out_h
);

    logic            valid_reg;
    sha_pkg::state_t v_reg, v_next;
    sha_pkg::sched_t w_reg, w_next;
    sha_pkg::state_t h_reg;

    // round function and schedule shift
    always_comb
    begin
        sha_pkg::word_t big1, ch, t1, big0, maj, t2, s0, s1, p, q;
        big1 = sha_pkg::rotr(in_v[4], 6) ^ sha_pkg::rotr(in_v[4], 11)
             ^ sha_pkg::rotr(in_v[4], 25);
        ch   = (in_v[4] & in_v[5]) ^ (~in_v[4] & in_v[6]);
        t1   = in_v[7] + big1 + ch + sha_pkg::round_k(RND) + in_w[0];
        big0 = sha_pkg::rotr(in_v[0], 2) ^ sha_pkg::rotr(in_v[0], 13)
             ^ sha_pkg::rotr(in_v[0], 22);
        maj  = (in_v[0] & in_v[1]) ^ (in_v[0] & in_v[2]) ^ (in_v[1] & in_v[2]);
        t2   = big0 + maj;
        v_next[7] = in_v[6];
        v_next[6] = in_v[5];
        v_next[5] = in_v[4];
        v_next[4] = in_v[3] + t1;
        v_next[3] = in_v[2];
        v_next[2] = in_v[1];
        v_next[1] = in_v[0];
        v_next[0] = t1 + t2;
        // window holds w[t..t+15]; next word is w[t+16]
        p  = in_w[1];
        q  = in_w[14];
        s0 = sha_pkg::rotr(p, 7) ^ sha_pkg::rotr(p, 18) ^ (p >> 3);
        s1 = sha_pkg::rotr(q, 17) ^ sha_pkg::rotr(q, 19) ^ (q >> 10);
        for (int i = 0; i < 15; i++)
        begin
            w_next[i] = in_w[i + 1];
        end
        w_next[15] = in_w[0] + s0 + in_w[9] + s1;
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= v_next;
            w_reg <= w_next;
            h_reg <= in_h;
        end
    end

    assign out_valid = valid_reg;
    assign out_v     = v_reg;
    assign out_w     = w_reg;
    assign out_h     = h_reg;

endmodule

### src/sha_block.sv
// 64-stage pipelined sha-256 compression plus final feed-forward add
// depends on sha_pkg, sha_round
module sha_block (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  sha_pkg::state_t in_h,
    input  sha_pkg::sched_t in_m,
    output logic            out_valid,
    output sha_pkg::state_t out_h
);

    logic            vld [0:sha_pkg::ROUNDS];
    sha_pkg::state_t vv  [0:sha_pkg::ROUNDS];
    sha_pkg::sched_t ww  [0:sha_pkg::ROUNDS];
    sha_pkg::state_t hh  [0:sha_pkg::ROUNDS];

    assign vld[0] = in_valid;
    assign vv[0]  = in_h;
    assign ww[0]  = in_m;
    assign hh[0]  = in_h;

    // one stage per round
    for (genvar r = 0; r < sha_pkg::ROUNDS; r++)
    begin : g_rnd
        sha_round #(.RND(6'(r))) u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (vld[r]),
            .in_v      (vv[r]),
            .in_w      (ww[r]),
            .in_h      (hh[r]),
            .out_valid (vld[r + 1]),
            .out_v     (vv[r + 1]),
            .out_w     (ww[r + 1]),
            .out_h     (hh[r + 1])
        );
    end

    logic            valid_reg;
    sha_pkg::state_t h_reg, h_next;

    // feed-forward add
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            h_next[i] = hh[sha_pkg::ROUNDS][i] + vv[sha_pkg::ROUNDS][i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= vld[sha_pkg::ROUNDS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg <= h_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_h     = h_reg;

endmodule

### src/sha256_pair_hash.sv
// top level: sha-256 of one 64-byte message, two pipelined compressions
// depends on sha_pkg, sha_block
//
// channel | signals                              | direction
// input   | in_valid, in_ready, message_0..7     | transaction into the block
// output  | out_valid, out_ready, digest_0..3    | transaction out of the block
//
// 64 round stages and one add stage per compression, two compressions; one
// transaction accepted per cycle when output is not stalled.
// rst_n clears every valid bit; payload registers are not reset.
// a stall freezes the whole pipeline, so nothing is lost or repeated.
module sha256_pair_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] message_0,
    input  logic [63:0] message_1,
    input  logic [63:0] message_2,
    input  logic [63:0] message_3,
    input  logic [63:0] message_4,
    input  logic [63:0] message_5,
    input  logic [63:0] message_6,
    input  logic [63:0] message_7,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_0,
    output logic [63:0] digest_1,
    output logic [63:0] digest_2,
    output logic [63:0] digest_3
);

    logic            en;
    logic            mid_valid;
    sha_pkg::state_t mid_h;
    sha_pkg::state_t fin_h;
    sha_pkg::sched_t msg;
    sha_pkg::sched_t pad;

    // pipeline advances unless a finished result waits
    assign en       = out_ready || !out_valid;
    assign in_ready = en;

    // split message into big-endian words
    assign msg = {message_7[31:0], message_7[63:32], message_6[31:0], message_6[63:32],
                  message_5[31:0], message_5[63:32], message_4[31:0], message_4[63:32],
                  message_3[31:0], message_3[63:32], message_2[31:0], message_2[63:32],
                  message_1[31:0], message_1[63:32], message_0[31:0], message_0[63:32]};

    // fixed padding block
    always_comb
    begin
        pad     = '0;
        pad[0]  = sha_pkg::PAD_FIRST;
        pad[15] = sha_pkg::PAD_LAST;
    end

    sha_block u_blk0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_h      (sha_pkg::INIT_H),
        .in_m      (msg),
        .out_valid (mid_valid),
        .out_h     (mid_h)
    );

    sha_block u_blk1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mid_valid),
        .in_h      (mid_h),
        .in_m      (pad),
        .out_valid (out_valid),
        .out_h     (fin_h)
    );

    // pack digest into four 64-bit outputs
    assign digest_0 = {fin_h[0], fin_h[1]};
    assign digest_1 = {fin_h[2], fin_h[3]};
    assign digest_2 = {fin_h[4], fin_h[5]};
    assign digest_3 = {fin_h[6], fin_h[7]};

endmodule

### src/sha256_pair_hash_checker.sv
// port-level checker for the sha-256 pair hash block, bound to the top level
// depends on sha256_pair_hash
module sha256_pair_hash_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] digest_0,
    input logic [63:0] digest_3
);

    // ready follows only the output side
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (out_ready || !out_valid))
        else $error("in_ready does not track output stall");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest_0) && $stable(digest_3))
        else $error("stalled result changed");

    // no result when reset is released
    a_rst: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result right after reset");

    // stalled cycle accepts nothing
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken during stall");

endmodule

bind sha256_pair_hash sha256_pair_hash_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .digest_0  (digest_0),
    .digest_3  (digest_3)
);

### test/tb_sha256_pair_hash.sv
// testbench for sha256_pair_hash: random and directed messages, digests checked
// against a behavioral sha-256 of one 64-byte block plus the fixed padding block
// depends on sha_pkg (word_t, state_t, INIT_H, PAD_FIRST, PAD_LAST) and the rtl
module tb_sha256_pair_hash;

    typedef struct {
        logic [63:0] msg [8];
    } message_t;

    typedef struct {
        logic [63:0] dig [4];
    } digest_t;

    localparam int NUM_RANDOM = 700;
    localparam int NUM_DIRECTED = 6;
    localparam int LATENCY = 130;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] message_0, message_1, message_2, message_3;
    logic [63:0] message_4, message_5, message_6, message_7;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] digest_0, digest_1, digest_2, digest_3;

    digest_t pending_digests [$];
    int      fail_count;
    int      send_idle_pct;
    int      recv_stall_pct;

    sha256_pair_hash uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .message_0(message_0), .message_1(message_1),
        .message_2(message_2), .message_3(message_3),
        .message_4(message_4), .message_5(message_5),
        .message_6(message_6), .message_7(message_7),
        .out_valid(out_valid), .out_ready(out_ready),
        .digest_0(digest_0), .digest_1(digest_1),
        .digest_2(digest_2), .digest_3(digest_3)
    );

    // clock, period 12
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // round constants
    function automatic sha_pkg::word_t k_of(input int t);
        sha_pkg::word_t kt [64] = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return kt[t];
    endfunction

    function automatic sha_pkg::word_t ror32(input sha_pkg::word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one compression of a 16-word block into the chaining state
    function automatic sha_pkg::state_t compress(input sha_pkg::state_t h,
                                                 input sha_pkg::word_t blk [16]);
        sha_pkg::word_t w [64];
        sha_pkg::word_t a, b, c, d, e, f, g, hh, t1, t2;
        sha_pkg::state_t r;
        for (int t = 0; t < 16; t++)
            w[t] = blk[t];
        for (int t = 16; t < 64; t++)
            w[t] = w[t-16] + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3))
                + w[t-7] + (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10));
        a = h[0]; b = h[1]; c = h[2]; d = h[3];
        e = h[4]; f = h[5]; g = h[6]; hh = h[7];
        for (int t = 0; t < 64; t++)
        begin
            t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
                + ((e & f) ^ (~e & g)) + k_of(t) + w[t];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
                + ((a & b) ^ (a & c) ^ (b & c));
            hh = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        r[0] = h[0] + a; r[1] = h[1] + b; r[2] = h[2] + c; r[3] = h[3] + d;
        r[4] = h[4] + e; r[5] = h[5] + f; r[6] = h[6] + g; r[7] = h[7] + hh;
        return r;
    endfunction

    // digest of one 64-byte message: message block, then the padding block
    function automatic digest_t sha256_of_message(input message_t m);
        sha_pkg::word_t  blk [16];
        sha_pkg::state_t h;
        digest_t d;
        for (int i = 0; i < 8; i++)
        begin
            blk[2*i]   = m.msg[i][63:32];
            blk[2*i+1] = m.msg[i][31:0];
        end
        h = compress(sha_pkg::INIT_H, blk);
        for (int i = 0; i < 16; i++)
            blk[i] = '0;
        blk[0]  = sha_pkg::PAD_FIRST;
        blk[15] = sha_pkg::PAD_LAST;
        h = compress(h, blk);
        for (int j = 0; j < 4; j++)
            d.dig[j] = {h[2*j], h[2*j+1]};
        return d;
    endfunction

    function automatic message_t random_message();
        message_t m;
        for (int i = 0; i < 8; i++)
            m.msg[i] = {$urandom(), $urandom()};
        return m;
    endfunction

    // send one transaction, valid held until accepted
    task automatic send_message(input message_t m);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        {message_0, message_1, message_2, message_3} = {m.msg[0], m.msg[1], m.msg[2], m.msg[3]};
        {message_4, message_5, message_6, message_7} = {m.msg[4], m.msg[5], m.msg[6], m.msg[7]};
        in_valid = 1'b1;
        pending_digests.push_back(sha256_of_message(m));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // receiver back pressure
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // output check
    always @(posedge clk)
    begin
        digest_t exp_d;
        logic [63:0] got [4];
        if (rst_n && out_valid && out_ready)
        begin
            got[0] = digest_0; got[1] = digest_1; got[2] = digest_2; got[3] = digest_3;
            if (pending_digests.size() == 0)
            begin
                $error("unexpected digest transaction");
                fail_count++;
            end
            else
            begin
                exp_d = pending_digests.pop_front();
                for (int j = 0; j < 4; j++)
                    if (got[j] !== exp_d.dig[j])
                    begin
                        $error("digest_%0d expected %h actual %h", j, exp_d.dig[j], got[j]);
                        fail_count++;
                    end
            end
        end
    end

    // run limit
    initial
    begin
        #3000000;
        $display("sha256_pair_hash test failed");
        $finish;
    end

    initial
    begin
        message_t dir_msg [NUM_DIRECTED];
        logic [63:0] dir_exp [NUM_DIRECTED];
        logic dir_known [NUM_DIRECTED];
        message_t m;
        digest_t d;
        int idle_phase;
        int wait_cycles;

        fail_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b1;
        {message_0, message_1, message_2, message_3} = '0;
        {message_4, message_5, message_6, message_7} = '0;

        // directed table; all-zero message digest is the well-known value
        for (int i = 0; i < 8; i++)
        begin
            dir_msg[0].msg[i] = 64'h0;
            dir_msg[1].msg[i] = 64'hffff_ffff_ffff_ffff;
            dir_msg[2].msg[i] = 64'haaaa_aaaa_aaaa_aaaa;
            dir_msg[3].msg[i] = 64'h5555_5555_5555_5555;
            dir_msg[4].msg[i] = (i == 0) ? 64'h8000_0000_0000_0000 : 64'h0;
            dir_msg[5].msg[i] = (i == 7) ? 64'h0000_0000_0000_0001 : 64'h0;
        end
        dir_exp = '{64'hf5a5fd42d16a2030, 0, 0, 0, 0, 0};
        dir_known = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            d = sha256_of_message(dir_msg[i]);
            if (dir_known[i] && d.dig[0] !== dir_exp[i])
            begin
                $error("digest_0 expected %h actual %h", dir_exp[i], d.dig[0]);
                fail_count++;
            end
            send_message(dir_msg[i]);
        end

        // random part in four idling phases
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            idle_phase = n / (NUM_RANDOM / 4);
            case (idle_phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            m = random_message();
            send_message(m);
        end

        // drain
        wait_cycles = 0;
        while (pending_digests.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0 && pending_digests.size() == 0)
            $display("sha256_pair_hash test passed");
        else
            $display("sha256_pair_hash test failed");
        $finish;
    end

endmodule
